// ----- hdl/dwt_pkg.sv -----
// Shared constants, types and arithmetic helpers for the multilevel wavelet analysis block.
`default_nettype none
package dwt_pkg;
    localparam int MAX_TAPS   = 32;
    localparam int MAX_LEVELS = 8;

    // fixed field widths
    localparam int TAP_W    = 16;
    localparam int SMP_W    = 16;
    localparam int VAL_W    = 24;
    localparam int IDX_W    = 15;
    localparam int LVLO_W   = 3;
    localparam int TIDX_W   = 5;
    localparam int ACC_W    = 48;
    localparam int PROD_W   = VAL_W + TAP_W;
    localparam int CFG_W    = 6;
    localparam int CFG_A_W  = 1;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_LEVELS = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_TAPS   = 1'd1;

    // item kinds
    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_MAC,
        S_DRAIN,
        S_DET,
        S_APP
    } t_state;

    // round half up at bit 14, then clamp to signed 24 bits
    function automatic logic [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]    v;
        logic signed [ACC_W-15:0]   q;
        logic [VAL_W-1:0]           r;
        v = acc + ACC_W'(signed'(8192));
        q = (ACC_W-14)'(v >>> 14);
        if (q > (ACC_W-14)'(signed'(8388607))) begin
            r = 24'h7FFFFF;
        end else if (q < (ACC_W-14)'(signed'(-8388608))) begin
            r = 24'h800000;
        end else begin
            r = q[VAL_W-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/dwt_in_if.sv -----
// Input channel: tap loads and signal samples.
`default_nettype none
interface dwt_in_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [dwt_pkg::TIDX_W-1:0]       tap_index;
    logic signed [dwt_pkg::TAP_W-1:0] low_tap;
    logic signed [dwt_pkg::TAP_W-1:0] high_tap;
    logic signed [dwt_pkg::SMP_W-1:0] sample;
    logic                             first;
    modport source(output valid, kind, tap_index, low_tap, high_tap, sample, first,
                   input ready);
    modport sink(input valid, kind, tap_index, low_tap, high_tap, sample, first,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/dwt_out_if.sv -----
// Output channel: wavelet coefficients.
`default_nettype none
interface dwt_out_if;
    logic                             valid;
    logic                             ready;
    logic [dwt_pkg::LVLO_W-1:0]       level;
    logic                             is_detail;
    logic [dwt_pkg::IDX_W-1:0]        index;
    logic signed [dwt_pkg::VAL_W-1:0] value;
    logic                             last;
    modport source(output valid, level, is_detail, index, value, last, input ready);
    modport sink(input valid, level, is_detail, index, value, last, output ready);
endinterface
`default_nettype wire

// ----- hdl/dwt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dwt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/multilevel_dwt_analysis.sv -----
// Top level: multilevel 1-D wavelet analysis with shared MAC pair over RAM history.
//
//  channel | dir | handshake      | payload
//  i_in    | in  | valid/ready    | kind, tap_index, low_tap, high_tap, sample, first
//  o_out   | out | valid/ready    | level, is_detail, index, value, last
//  cfg     | in  | i_cfg_we       | i_cfg_idx, i_cfg_data
//
// A tap item is written straight into the tap RAM. A sample item takes, per level reached, a
// history write state, then on odd phases a read of the history and tap RAMs per tap in use,
// a MAC drain and the detail and approximation result states. Output stalls hold the sequencer
// in its result states; ready drops while a sample runs. Synchronous active-low reset clears
// control state; no memory clearing pass is needed, per-level fill counts mask history not
// yet written.
`default_nettype none
module multilevel_dwt_analysis #(
    parameter int MAX_TAPS   = dwt_pkg::MAX_TAPS,
    parameter int MAX_LEVELS = dwt_pkg::MAX_LEVELS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [dwt_pkg::CFG_A_W-1:0] i_cfg_idx,
    input  wire logic [dwt_pkg::CFG_W-1:0]   i_cfg_data,
    dwt_in_if.sink                           i_in,
    dwt_out_if.source                        o_out
);
    localparam int PW  = $clog2(MAX_TAPS);
    localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int HD  = MAX_LEVELS * MAX_TAPS;
    localparam int HAW = $clog2(HD);
    localparam int TW  = 2 * dwt_pkg::TAP_W;
    localparam int VW  = dwt_pkg::VAL_W;

    // configuration
    logic [3:0] r_levels;
    logic [5:0] r_taps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= 4'd1;
            r_taps   <= 6'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dwt_pkg::CFG_LEVELS: r_levels <= i_cfg_data[3:0];
                dwt_pkg::CFG_TAPS:   r_taps   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped counts
    logic [6:0]    taps_c;
    logic [4:0]    lev_c;
    logic [PW-1:0] j_last;
    logic [LW-1:0] lvl_last;

    always_comb begin
        if (r_taps == 6'd0) begin
            taps_c = 7'd1;
        end else if ({1'b0, r_taps} > 7'(MAX_TAPS)) begin
            taps_c = 7'(MAX_TAPS);
        end else begin
            taps_c = {1'b0, r_taps};
        end
        if (r_levels == 4'd0) begin
            lev_c = 5'd1;
        end else if ({1'b0, r_levels} > 5'(MAX_LEVELS)) begin
            lev_c = 5'(MAX_LEVELS);
        end else begin
            lev_c = {1'b0, r_levels};
        end
        j_last   = PW'(taps_c - 7'd1);
        lvl_last = LW'(lev_c - 5'd1);
    end

    // sequencer state and per-level bookkeeping
    dwt_pkg::t_state r_state, n_state;
    logic [LW-1:0]     r_lvl;
    logic [VW-1:0]     r_x;
    logic [PW-1:0]     r_j;
    logic [PW-1:0]     r_rp;
    logic [PW:0]       r_fill_cur;
    logic              r_phase [MAX_LEVELS];
    logic [dwt_pkg::IDX_W-1:0] r_cnt [MAX_LEVELS];
    logic [PW-1:0]     r_ptr   [MAX_LEVELS];
    logic [PW:0]       r_fill  [MAX_LEVELS];

    // MAC pipeline
    logic                             r_s1_v, r_s1_ok, r_s2_v;
    logic signed [dwt_pkg::PROD_W-1:0] r_plo, r_phi;
    logic signed [dwt_pkg::ACC_W-1:0]  r_alo, r_ahi;

    // output register
    logic                        r_ov;
    logic [dwt_pkg::LVLO_W-1:0]  r_olevel;
    logic                        r_odet;
    logic [dwt_pkg::IDX_W-1:0]   r_oidx;
    logic [VW-1:0]               r_oval;
    logic                        r_olast;

    logic out_free;
    logic take;
    logic issue;
    logic det_load, app_load;
    logic app_last;
    logic [PW-1:0] nptr;
    logic [PW:0]   nfill;
    logic [VW-1:0] det_val, app_val;

    assign out_free = !r_ov || o_out.ready;
    assign take     = i_in.valid && i_in.ready;
    assign nptr     = (r_ptr[r_lvl] == PW'(MAX_TAPS - 1)) ? '0 : r_ptr[r_lvl] + 1'b1;
    assign nfill    = (r_fill[r_lvl] == (PW+1)'(MAX_TAPS)) ? r_fill[r_lvl]
                                                          : r_fill[r_lvl] + 1'b1;
    assign det_val  = dwt_pkg::round_sat(r_ahi);
    assign app_val  = dwt_pkg::round_sat(r_alo);

    // last result of the item: final level or next level still on its even phase
    always_comb begin
        if (r_lvl == lvl_last) begin
            app_last = 1'b1;
        end else begin
            app_last = !r_phase[LW'(r_lvl + 1'b1)];
        end
    end

    // memories
    logic            tap_we;
    logic [PW-1:0]   tap_waddr;
    logic [TW-1:0]   tap_rdata;
    logic            h_we;
    logic [HAW-1:0]  h_waddr, h_raddr;
    logic [VW-1:0]   h_rdata;

    assign tap_we    = take && (i_in.kind == dwt_pkg::KIND_TAP) &&
                       ({2'b0, i_in.tap_index} < 7'(MAX_TAPS));
    assign tap_waddr = PW'(i_in.tap_index);
    assign h_we      = (r_state == dwt_pkg::S_WRITE);
    assign h_waddr   = HAW'(HAW'(r_lvl) * HAW'(MAX_TAPS)) + HAW'(nptr);
    assign h_raddr   = HAW'(HAW'(r_lvl) * HAW'(MAX_TAPS)) + HAW'(r_rp);

    dwt_ram #(.WIDTH(TW), .DEPTH(MAX_TAPS)) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (tap_we),
        .i_waddr (tap_waddr),
        .i_wdata ({i_in.low_tap, i_in.high_tap}),
        .i_raddr (r_j),
        .o_rdata (tap_rdata)
    );

    dwt_ram #(.WIDTH(VW), .DEPTH(HD)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (r_x),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // next state and strobes
    always_comb begin
        n_state  = r_state;
        issue    = 1'b0;
        det_load = 1'b0;
        app_load = 1'b0;
        unique case (r_state)
            dwt_pkg::S_IDLE: begin
                if (take && i_in.kind == dwt_pkg::KIND_SAMPLE) begin
                    n_state = dwt_pkg::S_WRITE;
                end
            end
            dwt_pkg::S_WRITE: begin
                n_state = r_phase[r_lvl] ? dwt_pkg::S_MAC : dwt_pkg::S_IDLE;
            end
            dwt_pkg::S_MAC: begin
                issue = 1'b1;
                if (r_j == j_last) begin
                    n_state = dwt_pkg::S_DRAIN;
                end
            end
            dwt_pkg::S_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_state = dwt_pkg::S_DET;
                end
            end
            dwt_pkg::S_DET: begin
                if (out_free) begin
                    det_load = 1'b1;
                    n_state  = dwt_pkg::S_APP;
                end
            end
            dwt_pkg::S_APP: begin
                if (out_free) begin
                    app_load = 1'b1;
                    n_state  = (r_lvl == lvl_last) ? dwt_pkg::S_IDLE : dwt_pkg::S_WRITE;
                end
            end
            default: n_state = dwt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // per-level state, sample and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_phase[l] <= 1'b0;
                r_cnt[l]   <= '0;
                r_ptr[l]   <= '0;
                r_fill[l]  <= '0;
            end
            r_lvl <= '0;
        end else begin
            if (take && i_in.kind == dwt_pkg::KIND_SAMPLE) begin
                r_lvl <= '0;
                if (i_in.first) begin
                    for (int l = 0; l < MAX_LEVELS; l++) begin
                        r_phase[l] <= 1'b0;
                        r_cnt[l]   <= '0;
                        r_ptr[l]   <= '0;
                        r_fill[l]  <= '0;
                    end
                end
            end
            if (r_state == dwt_pkg::S_WRITE) begin
                r_ptr[r_lvl]   <= nptr;
                r_fill[r_lvl]  <= nfill;
                r_phase[r_lvl] <= !r_phase[r_lvl];
            end
            if (app_load) begin
                r_cnt[r_lvl] <= r_cnt[r_lvl] + 1'b1;
                if (r_lvl != lvl_last) begin
                    r_lvl <= r_lvl + 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x <= VW'(i_in.sample);
        end
        if (r_state == dwt_pkg::S_WRITE) begin
            r_j        <= '0;
            r_rp       <= nptr;
            r_fill_cur <= nfill;
        end
        if (issue) begin
            r_j  <= r_j + 1'b1;
            r_rp <= (r_rp == '0) ? PW'(MAX_TAPS - 1) : r_rp - 1'b1;
        end
        if (app_load) begin
            r_x <= app_val;
        end
    end

    // MAC pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
        end
        r_s1_ok <= ({1'b0, r_j} < r_fill_cur);
        if (r_s1_ok) begin
            r_plo <= $signed(h_rdata) * $signed(tap_rdata[TW-1:dwt_pkg::TAP_W]);
            r_phi <= $signed(h_rdata) * $signed(tap_rdata[dwt_pkg::TAP_W-1:0]);
        end else begin
            r_plo <= '0;
            r_phi <= '0;
        end
        if (r_state == dwt_pkg::S_WRITE) begin
            r_alo <= '0;
            r_ahi <= '0;
        end else if (r_s2_v) begin
            r_alo <= r_alo + dwt_pkg::ACC_W'(r_plo);
            r_ahi <= r_ahi + dwt_pkg::ACC_W'(r_phi);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (det_load || app_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (det_load || app_load) begin
            r_olevel <= dwt_pkg::LVLO_W'(r_lvl);
            r_odet   <= det_load;
            r_oidx   <= r_cnt[r_lvl];
            r_oval   <= det_load ? det_val : app_val;
            r_olast  <= app_load && app_last;
        end
    end

    assign i_in.ready      = (r_state == dwt_pkg::S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.level     = r_olevel;
    assign o_out.is_detail = r_odet;
    assign o_out.index     = r_oidx;
    assign o_out.value     = r_oval;
    assign o_out.last      = r_olast;
endmodule
`default_nettype wire

// ----- hdl/dwt_chk.sv -----
// Port-level checker for the wavelet analysis block, with its bind.
`default_nettype none
module dwt_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_kind,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_det,
    input wire logic i_out_last,
    input wire logic [dwt_pkg::VAL_W-1:0] i_out_value
);
    // a sample keeps the input closed on the next cycle
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind == dwt_pkg::KIND_SAMPLE |=> !i_in_ready)
        else $error("input open right after a sample");

    // a detail is never flagged last; its approximation always follows
    a_det_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_det |-> !i_out_last)
        else $error("detail item flagged last");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid after reset");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled output changed");
endmodule

bind multilevel_dwt_analysis dwt_chk u_dwt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_det   (o_out.is_detail),
    .i_out_last  (o_out.last),
    .i_out_value (o_out.value)
);
`default_nettype wire

// ----- tb/multilevel_dwt_analysis_tb.sv -----
// Self-checking testbench for the multilevel wavelet analysis block.
`timescale 1ns / 100ps
module multilevel_dwt_analysis_tb;
    localparam int SETTLE     = 400;      // idle cycles after the last result
    localparam int CYCLE_MAX  = 1000000;
    localparam int N_DIRECTED = 22;
    localparam int N_SEGMENTS = 12;
    localparam int SEG_ITEMS  = 30;

    // local shorthands for package widths
    localparam int VW  = dwt_pkg::VAL_W;
    localparam int AW  = dwt_pkg::ACC_W;
    localparam int TPW = dwt_pkg::TAP_W;
    localparam int SW  = dwt_pkg::SMP_W;
    localparam int XW  = dwt_pkg::TIDX_W;
    localparam int LOW = dwt_pkg::LVLO_W;
    localparam int CW  = dwt_pkg::CFG_W;
    localparam int NT  = dwt_pkg::MAX_TAPS;
    localparam int NL  = dwt_pkg::MAX_LEVELS;

    typedef struct packed {
        logic [dwt_pkg::LVLO_W-1:0]       level;
        logic                             is_detail;
        logic [dwt_pkg::IDX_W-1:0]        index;
        logic signed [dwt_pkg::VAL_W-1:0] value;
        logic                             last;
    } t_coef;

    typedef struct {
        logic                             kind;
        logic [dwt_pkg::TIDX_W-1:0]       tidx;
        logic signed [dwt_pkg::TAP_W-1:0] lo;
        logic signed [dwt_pkg::TAP_W-1:0] hi;
        logic signed [dwt_pkg::SMP_W-1:0] smp;
        logic                             first;
        bit                               typed;
        int                               det;
        int                               app;
    } t_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic [dwt_pkg::CFG_A_W-1:0] cfg_idx;
    logic [dwt_pkg::CFG_W-1:0]   cfg_data;

    dwt_in_if  in_ch ();
    dwt_out_if out_ch ();

    multilevel_dwt_analysis dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    // predictor state
    logic signed [TPW-1:0]           lp_taps [NT];
    logic signed [TPW-1:0]           hp_taps [NT];
    logic signed [VW-1:0]            hist [NL][NT];
    logic                            phase [NL];
    logic [dwt_pkg::IDX_W-1:0]       count [NL];
    logic [3:0]                      cfg_levels;
    logic [5:0]                      cfg_taps;

    t_coef pending_coefs [$];
    int    errors;
    int    cycles;
    int    coefs_seen;
    int    items_sent;
    int    send_idle;
    int    recv_idle;

    t_row dir_rows [N_DIRECTED] = '{
        '{dwt_pkg::KIND_TAP,    0,  16384,  16384,  32767, 1, 0,      0,   0},
        '{dwt_pkg::KIND_TAP,    1,  16384, -16384, -32768, 0, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,    100, 1, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 31,    -1,     -1,     40, 0, 1,    -60, 140},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,  32767, 1, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0, -32768, 0, 1, -65535,  -1},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,      0, 0, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,      0, 0, 1,      0,   0},
        '{dwt_pkg::KIND_TAP,    0,   8192,   8192,      0, 0, 0,      0,   0},
        '{dwt_pkg::KIND_TAP,    1,   8192,  -8192,      0, 0, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,      1, 1, 0,      0,   0},
        // halves round up
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,      2, 0, 1,      1,   2},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,     -1, 1, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,     -2, 0, 1,      0,  -1},
        '{dwt_pkg::KIND_TAP,    0, -32768,  32767,      0, 0, 0,      0,   0},
        '{dwt_pkg::KIND_TAP,    1,  32767, -32768,      0, 0, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0, -32768, 1, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0, -32768, 0, 1,      2,   2},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,  32767, 0, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,  32767, 0, 1,     -2,  -2},
        // tap item with first set must not clear history
        '{dwt_pkg::KIND_TAP,    2,      0,      0,   1234, 1, 0,      0,   0},
        '{dwt_pkg::KIND_SAMPLE, 0,      0,      0,      5, 0, 0,      0,   0}
    };

    // level/taps settings per segment, extremes and out-of-range values included
    int seg_levels [N_SEGMENTS] = '{1, 8, 0, 15, 4, 8, 3, 2, 6, 8, 5, 7};
    int seg_taps   [N_SEGMENTS] = '{1, 32, 0, 63, 7, 2, 32, 16, 5, 32, 1, 12};

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [VW-1:0] round_clip(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] q;
        q = (acc + 48'sd8192) >>> 14;
        if (q > 48'sd8388607) return 24'sh7FFFFF;
        if (q < -48'sd8388608) return 24'sh800000;
        return q[VW-1:0];
    endfunction

    // wavelet cascade for one accepted sample; results go to pending_coefs
    task automatic cascade_sample(input logic signed [SW-1:0] smp, input logic first);
        int nlev;
        int ntaps;
        logic signed [VW-1:0] x;
        logic signed [AW-1:0] acc_lo;
        logic signed [AW-1:0] acc_hi;
        t_coef c;
        int produced;
        if (first) begin
            foreach (hist[l, j]) hist[l][j] = '0;
            foreach (phase[l]) begin
                phase[l] = 1'b0;
                count[l] = '0;
            end
        end
        nlev  = (cfg_levels == 0) ? 1 : (cfg_levels > NL ? NL : cfg_levels);
        ntaps = (cfg_taps == 0) ? 1 : (cfg_taps > NT ? NT : cfg_taps);
        x = VW'(smp);
        produced = 0;
        for (int l = 0; l < nlev; l++) begin
            for (int j = NT - 1; j > 0; j--) hist[l][j] = hist[l][j-1];
            hist[l][0] = x;
            acc_lo = '0;
            acc_hi = '0;
            for (int j = 0; j < ntaps; j++) begin
                acc_lo += AW'(hist[l][j]) * AW'(lp_taps[j]);
                acc_hi += AW'(hist[l][j]) * AW'(hp_taps[j]);
            end
            if (!phase[l]) begin
                phase[l] = 1'b1;
                break;
            end
            phase[l] = 1'b0;
            c.level     = LOW'(l);
            c.index     = count[l];
            c.last      = 1'b0;
            c.is_detail = 1'b1;
            c.value     = round_clip(acc_hi);
            pending_coefs.push_back(c);
            c.is_detail = 1'b0;
            c.value     = round_clip(acc_lo);
            pending_coefs.push_back(c);
            count[l] = count[l] + 1'b1;
            x = c.value;
            produced += 2;
        end
        if (produced > 0) pending_coefs[$].last = 1'b1;
    endtask

    // drive one item, wait for acceptance, then update the predictor
    task automatic push_item(input t_row r);
        int n_prior;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= r.kind;
        in_ch.tap_index <= r.tidx;
        in_ch.low_tap   <= r.lo;
        in_ch.high_tap  <= r.hi;
        in_ch.sample    <= r.smp;
        in_ch.first     <= r.first;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (r.kind == dwt_pkg::KIND_TAP) begin
            lp_taps[r.tidx] = r.lo;
            hp_taps[r.tidx] = r.hi;
        end else begin
            n_prior = pending_coefs.size();
            cascade_sample(r.smp, r.first);
            // typed rows: the table value is what the block must produce
            if (r.typed) begin
                if (pending_coefs.size() != n_prior + 2 ||
                    pending_coefs[n_prior].value != VW'(r.det) ||
                    pending_coefs[n_prior+1].value != VW'(r.app)) begin
                    errors++;
                    if (errors <= 10)
                        $display("table row disagrees with predictor: det %0d app %0d",
                                 r.det, r.app);
                end else begin
                    pending_coefs[n_prior].value   = VW'(r.det);
                    pending_coefs[n_prior+1].value = VW'(r.app);
                end
            end
        end
    endtask

    // drain all results and let the block go idle, then write a register
    task automatic write_cfg(input logic [dwt_pkg::CFG_A_W-1:0] idx, input int data);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_coefs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CW'(data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == dwt_pkg::CFG_LEVELS) cfg_levels = 4'(data);
        else cfg_taps = 6'(data);
    endtask

    function automatic logic signed [TPW-1:0] rand_tap();
        if ($urandom_range(99) < 75) return TPW'($urandom_range(12000)) - 16'sd6000;
        return TPW'($urandom);
    endfunction

    task automatic rand_item(output t_row r);
        r.kind  = ($urandom_range(99) < 15) ? dwt_pkg::KIND_TAP : dwt_pkg::KIND_SAMPLE;
        r.tidx  = XW'($urandom);
        r.lo    = rand_tap();
        r.hi    = rand_tap();
        r.smp   = SW'($urandom);
        r.first = (r.kind == dwt_pkg::KIND_TAP) ? 1'($urandom) : ($urandom_range(99) < 2);
        r.typed = 0;
        r.det   = 0;
        r.app   = 0;
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // result checker
    always @(posedge i_clk) begin
        t_coef got;
        t_coef want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.level     = out_ch.level;
            got.is_detail = out_ch.is_detail;
            got.index     = out_ch.index;
            got.value     = out_ch.value;
            got.last      = out_ch.last;
            coefs_seen++;
            if (pending_coefs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result lvl %0d det %0d idx %0d val %0d",
                             got.level, got.is_detail, got.index, got.value);
            end else begin
                want = pending_coefs.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp lvl %0d det %0d idx %0d val %0d last %0d",
                                  " / got %0d %0d %0d %0d %0d"},
                                 want.level, want.is_detail, want.index, want.value,
                                 want.last, got.level, got.is_detail, got.index,
                                 got.value, got.last);
                end
            end
        end
    end

    // main sequence
    initial begin
        t_row r;
        in_ch.valid     = 1'b0;
        in_ch.kind      = dwt_pkg::KIND_TAP;
        in_ch.tap_index = '0;
        in_ch.low_tap   = '0;
        in_ch.high_tap  = '0;
        in_ch.sample    = '0;
        in_ch.first     = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = dwt_pkg::CFG_LEVELS;
        cfg_data        = '0;
        i_rst_n         = 1'b0;
        errors          = 0;
        cycles          = 0;
        coefs_seen      = 0;
        items_sent      = 0;
        send_idle       = 9;
        recv_idle       = 57;
        cfg_levels      = 4'd1;
        cfg_taps        = 6'd2;
        foreach (lp_taps[j]) begin
            lp_taps[j] = '0;
            hp_taps[j] = '0;
        end
        foreach (hist[l, j]) hist[l][j] = '0;
        foreach (phase[l]) begin
            phase[l] = 1'b0;
            count[l] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table at reset settings
        for (int i = 0; i < N_DIRECTED; i++) push_item(dir_rows[i]);

        // load every tap before wider filters are used
        for (int j = 0; j < NT; j++) begin
            rand_item(r);
            r.kind = dwt_pkg::KIND_TAP;
            r.tidx = XW'(j);
            push_item(r);
        end

        // random segments, each under its own register setting
        for (int s = 0; s < N_SEGMENTS; s++) begin
            if (s == 4) begin
                send_idle = 57;
                recv_idle = 9;
            end else if (s == 8) begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_cfg(dwt_pkg::CFG_LEVELS, seg_levels[s]);
            write_cfg(dwt_pkg::CFG_TAPS, seg_taps[s]);
            for (int i = 0; i < SEG_ITEMS; i++) begin
                rand_item(r);
                push_item(r);
            end
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_coefs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("sent %0d items, checked %0d coefficients over %0d register settings",
                 items_sent, coefs_seen, N_SEGMENTS + 1);
        $display("mismatches: %0d", errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
